@@ rtl/msct_pkg.sv @@
`default_nettype none
package msct_pkg;

  localparam int unsigned DefNumCores = 4;
  localparam int unsigned DefSets     = 64;
  localparam int unsigned DefWays     = 4;
  localparam int unsigned TagW        = 30;

  typedef enum logic [1:0] {
    KindRead  = 2'd0,
    KindWrite = 2'd1,
    KindFlush = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StI = 2'd0,
    StM = 2'd1,
    StE = 2'd2,
    StS = 2'd3
  } mesi_e;

  typedef enum logic [1:0] {
    CfgActiveCores = 2'd0,
    CfgWaysInUse   = 2'd1,
    CfgBlockLog2   = 2'd2,
    CfgSetBits     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic latch_in;
    logic rd_req;
    logic rd_snoop;
    logic look;
    logic snoop_chk;
    logic install;
    logic load_out;
    logic out_flush;
    logic flush_clear;
    logic cnt_clr;
    logic cnt_inc;
  } msct_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic is_write;
    logic ignore;
    logic found;
    logic shared;
    logic req_hit;
    logic cnt_end;
    logic cnt_req;
    logic cnt_last;
    logic out_free;
  } msct_sts_t;

  function automatic int unsigned max_set_bits(int unsigned sets);
    int unsigned b;
    b = 0;
    for (int i = 0; i < 7; i++) begin
      if ((2 << b) <= sets) begin
        b = b + 1;
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/msct_if.sv @@
`default_nettype none
interface msct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  core;
  logic [31:0] address;
  modport source (output valid, kind, core, address, input ready);
  modport sink (input valid, kind, core, address, output ready);
endinterface

interface msct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  core_id;
  logic        hit;
  logic        broadcast;
  logic        replaced;
  logic [10:0] fetch_words;
  logic [18:0] writeback_words;
  logic        supplier_valid;
  logic [1:0]  supplier_core;
  logic [10:0] supplier_copy_words;
  logic [1:0]  new_state;
  logic        last;
  modport source (output valid, core_id, hit, broadcast, replaced, fetch_words,
                  writeback_words, supplier_valid, supplier_core,
                  supplier_copy_words, new_state, last, input ready);
  modport sink (input valid, core_id, hit, broadcast, replaced, fetch_words,
                writeback_words, supplier_valid, supplier_core,
                supplier_copy_words, new_state, last, output ready);
endinterface

interface msct_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [3:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/msct_ram.sv @@
`default_nettype none
module msct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/msct_ctrl.sv @@
`default_nettype none
module msct_ctrl
  import msct_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire msct_sts_t sts_i,
  output msct_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    SIdle     = 8'b0000_0001,
    SDecode   = 8'b0000_0010,
    SLook     = 8'b0000_0100,
    SSnoopRd  = 8'b0000_1000,
    SSnoopChk = 8'b0001_0000,
    SInstall  = 8'b0010_0000,
    SEmit     = 8'b0100_0000,
    SFlush    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = SDecode;
        end
      end
      SDecode: begin
        if (sts_i.is_flush) begin
          cmd_o.cnt_clr = 1'b1;
          state_d = SFlush;
        end else if (sts_i.ignore) begin
          state_d = SIdle;
        end else begin
          cmd_o.rd_req = 1'b1;
          state_d = SLook;
        end
      end
      SLook: begin
        cmd_o.look    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.found && !(sts_i.is_write && sts_i.shared)) begin
          state_d = SEmit;
        end else begin
          state_d = SSnoopRd;
        end
      end
      SSnoopRd: begin
        if (sts_i.cnt_end) begin
          state_d = sts_i.req_hit ? SEmit : SInstall;
        end else if (sts_i.cnt_req) begin
          cmd_o.cnt_inc = 1'b1;
        end else begin
          cmd_o.rd_snoop = 1'b1;
          state_d = SSnoopChk;
        end
      end
      SSnoopChk: begin
        cmd_o.snoop_chk = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (!sts_i.is_write && sts_i.found) begin
          state_d = SInstall;
        end else begin
          state_d = SSnoopRd;
        end
      end
      SInstall: begin
        cmd_o.install = 1'b1;
        state_d = SEmit;
      end
      SEmit: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = SIdle;
        end
      end
      SFlush: begin
        if (sts_i.out_free) begin
          cmd_o.load_out  = 1'b1;
          cmd_o.out_flush = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          if (sts_i.cnt_last) begin
            cmd_o.flush_clear = 1'b1;
            state_d = SIdle;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/msct_dp.sv @@
`default_nettype none
module msct_dp
  import msct_pkg::*;
#(
  parameter int unsigned NUM_CORES = DefNumCores,
  parameter int unsigned SETS      = DefSets,
  parameter int unsigned WAYS      = DefWays
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  msct_in_if.sink    in_i,
  msct_out_if.source out_o,
  msct_cfg_if.sink   cfg_i,
  input  wire msct_cmd_t cmd_i,
  output msct_sts_t  sts_o
);

  localparam int unsigned CoreW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned CntW    = $clog2(NUM_CORES + 1);
  localparam int unsigned SetW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned Rows    = NUM_CORES * SETS;
  localparam int unsigned RowW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned RankW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned FillW   = $clog2(WAYS + 1);
  localparam int unsigned MCntW   = $clog2(SETS * WAYS + 1);
  localparam int unsigned RowBits = WAYS * (2 + RankW + TagW);
  localparam int unsigned MaxSb   = max_set_bits(SETS);

  typedef logic [WAYS-1:0][1:0]       st_row_t;
  typedef logic [WAYS-1:0][RankW-1:0] rk_row_t;
  typedef logic [WAYS-1:0][TagW-1:0]  tg_row_t;

  function automatic logic [FillW-1:0] count_st(st_row_t st, logic valid_only);
    logic [FillW-1:0] n;
    n = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_only ? (st[w] != StI) : (st[w] == StM)) begin
        n = n + FillW'(1);
      end
    end
    return n;
  endfunction

  // Configuration registers.
  logic [2:0] act_q, ways_q, sbits_q;
  logic [3:0] blog_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 3'd4;
      ways_q  <= 3'd4;
      blog_q  <= 4'd5;
      sbits_q <= 3'd6;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgActiveCores: act_q   <= cfg_i.data[2:0];
        CfgWaysInUse:   ways_q  <= cfg_i.data[2:0];
        CfgBlockLog2:   blog_q  <= cfg_i.data;
        CfgSetBits:     sbits_q <= cfg_i.data[2:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0]  ncores;
  logic [FillW-1:0] ways_lim;
  logic [3:0]       blog;
  logic [2:0]       sbits;
  logic [10:0]      words;

  always_comb begin
    if (act_q == '0) begin
      ncores = CntW'(1);
    end else if (32'(act_q) > NUM_CORES) begin
      ncores = CntW'(NUM_CORES);
    end else begin
      ncores = CntW'(act_q);
    end
    if (ways_q == '0) begin
      ways_lim = FillW'(1);
    end else if (32'(ways_q) > WAYS) begin
      ways_lim = FillW'(WAYS);
    end else begin
      ways_lim = FillW'(ways_q);
    end
    if (blog_q < 4'd2) begin
      blog = 4'd2;
    end else if (blog_q > 4'd12) begin
      blog = 4'd12;
    end else begin
      blog = blog_q;
    end
    if (32'(sbits_q) > MaxSb) begin
      sbits = 3'(MaxSb);
    end else begin
      sbits = sbits_q;
    end
  end

  assign words = 11'(1) << (blog - 4'd2);

  // Item registers and address split.
  logic [1:0]  kind_q, core_q;
  logic [31:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_i.kind;
      core_q <= in_i.core;
      addr_q <= in_i.address;
    end
  end

  logic [TagW-1:0] tag;
  logic [SetW-1:0] set_idx;
  logic [31:0]     set_full;
  logic [4:0]      shamt;
  logic            is_write;

  assign shamt    = 5'(blog) + 5'(sbits);
  assign tag      = TagW'(addr_q >> shamt);
  assign set_full = addr_q >> blog;
  assign set_idx  = SetW'(set_full) & SetW'((32'd1 << sbits) - 32'd1);
  assign is_write = (kind_q == KindWrite);

  // Core counter for snooping and flush reporting.
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  logic [RowW-1:0] req_addr, snp_addr;

  assign req_addr = RowW'(32'(core_q) * SETS + 32'(set_idx));
  assign snp_addr = RowW'(32'(cnt_q) * SETS + 32'(set_idx));

  // Row memory and row valid bits.
  logic               ram_we, ram_re;
  logic [RowW-1:0]    ram_waddr, ram_raddr;
  logic [RowBits-1:0] ram_wdata, ram_rdata;
  logic [Rows-1:0]    rv_q;
  logic               rv_rd_q;

  assign ram_re    = cmd_i.rd_req || cmd_i.rd_snoop;
  assign ram_raddr = cmd_i.rd_snoop ? snp_addr : req_addr;

  msct_ram #(
    .Width (RowBits),
    .Depth (Rows)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q    <= '0;
      rv_rd_q <= 1'b0;
    end else begin
      if (ram_re) begin
        rv_rd_q <= rv_q[ram_raddr];
      end
      if (cmd_i.flush_clear) begin
        rv_q <= '0;
      end else if (ram_we) begin
        rv_q[ram_waddr] <= 1'b1;
      end
    end
  end

  st_row_t rd_st_raw, rd_st;
  rk_row_t rd_rk_raw, rd_rk;
  tg_row_t rd_tg;

  assign {rd_st_raw, rd_rk_raw, rd_tg} = ram_rdata;
  assign rd_st = rv_rd_q ? rd_st_raw : '0;
  assign rd_rk = rv_rd_q ? rd_rk_raw : '0;

  logic [WAYS-1:0]  match;
  logic [RankW-1:0] way;
  logic             found;
  logic [1:0]       cur_st;
  logic [RankW-1:0] cur_rk;

  always_comb begin
    way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = (rd_st[w] != StI) && (rd_tg[w] == tag);
      if (match[w]) begin
        way = RankW'(w);
      end
    end
  end

  assign found  = |match;
  assign cur_st = rd_st[way];
  assign cur_rk = rd_rk[way];

  // Requester hit: most recent, Modified on a write.
  st_row_t h_st;
  rk_row_t h_rk;

  always_comb begin
    h_st = rd_st;
    h_rk = rd_rk;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_st[w] != StI && rd_rk[w] < cur_rk) begin
        h_rk[w] = rd_rk[w] + RankW'(1);
      end
    end
    h_rk[way] = '0;
    if (is_write) begin
      h_st[way] = StM;
    end
  end

  // Snooped row: Shared on a read, dropped on a write.
  st_row_t s_st;
  rk_row_t s_rk;

  always_comb begin
    s_st = rd_st;
    s_rk = rd_rk;
    if (is_write) begin
      s_st[way] = StI;
      s_rk[way] = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (s_st[w] != StI && rd_rk[w] > cur_rk) begin
          s_rk[w] = rd_rk[w] - RankW'(1);
        end
      end
    end else begin
      s_st[way] = StS;
    end
  end

  // Install into the saved requester row.
  st_row_t req_st_q, d_st, i_st;
  rk_row_t req_rk_q, d_rk, i_rk;
  tg_row_t req_tg_q, i_tg;

  logic             sup_v_q;
  logic [FillW-1:0] fill;
  logic [RankW-1:0] vic, pick, vic_rk;
  logic             full, pfound, vic_mod;
  logic [1:0]       ins_st;

  assign ins_st = is_write ? StM : (sup_v_q ? StS : StE);

  always_comb begin
    fill = count_st(req_st_q, 1'b1);
    full = (fill >= ways_lim);
    vic  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (req_st_q[w] != StI && req_rk_q[w] == RankW'(fill - FillW'(1))) begin
        vic = RankW'(w);
      end
    end
    vic_rk  = req_rk_q[vic];
    vic_mod = full && (req_st_q[vic] == StM);
    d_st    = req_st_q;
    d_rk    = req_rk_q;
    if (full) begin
      d_st[vic] = StI;
      d_rk[vic] = '0;
      for (int w = 0; w < WAYS; w++) begin
        if (d_st[w] != StI && req_rk_q[w] > vic_rk) begin
          d_rk[w] = req_rk_q[w] - RankW'(1);
        end
      end
    end
    pick   = '0;
    pfound = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (d_st[w] == StI) begin
        pick   = RankW'(w);
        pfound = 1'b1;
      end
    end
    i_st = d_st;
    i_rk = d_rk;
    i_tg = req_tg_q;
    if (pfound) begin
      for (int w = 0; w < WAYS; w++) begin
        if (d_st[w] != StI) begin
          i_rk[w] = d_rk[w] + RankW'(1);
        end
      end
      i_st[pick] = ins_st;
      i_tg[pick] = tag;
      i_rk[pick] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      req_st_q <= rd_st;
      req_rk_q <= rd_rk;
      req_tg_q <= rd_tg;
    end
  end

  // Write port and Modified line counters.
  st_row_t         old_st, new_st;
  logic [CntW-1:0] wcore;
  logic [MCntW-1:0] mcnt_q [NUM_CORES];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req_addr;
    old_st    = rd_st;
    new_st    = h_st;
    ram_wdata = {h_st, h_rk, rd_tg};
    wcore     = CntW'(core_q);
    if (cmd_i.look && found) begin
      ram_we = 1'b1;
    end else if (cmd_i.snoop_chk && found) begin
      ram_we    = 1'b1;
      ram_waddr = snp_addr;
      new_st    = s_st;
      ram_wdata = {s_st, s_rk, rd_tg};
      wcore     = cnt_q;
    end else if (cmd_i.install) begin
      ram_we    = 1'b1;
      old_st    = req_st_q;
      new_st    = i_st;
      ram_wdata = {i_st, i_rk, i_tg};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        mcnt_q[c] <= '0;
      end
    end else if (cmd_i.flush_clear) begin
      for (int c = 0; c < NUM_CORES; c++) begin
        mcnt_q[c] <= '0;
      end
    end else if (ram_we) begin
      mcnt_q[CoreW'(wcore)] <= mcnt_q[CoreW'(wcore)]
                               - MCntW'(count_st(old_st, 1'b0))
                               + MCntW'(count_st(new_st, 1'b0));
    end
  end

  // Result fields of the current access.
  logic        hit_q, bc_q, rep_q;
  logic [10:0] fetch_q, copy_q;
  logic [18:0] wb_q;
  logic [1:0]  sup_c_q, ns_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      hit_q   <= 1'b0;
      bc_q    <= 1'b0;
      rep_q   <= 1'b0;
      fetch_q <= '0;
      copy_q  <= '0;
      wb_q    <= '0;
      sup_v_q <= 1'b0;
      sup_c_q <= '0;
      ns_q    <= StI;
    end else if (cmd_i.look) begin
      if (found) begin
        hit_q <= 1'b1;
        ns_q  <= is_write ? StM : cur_st;
        bc_q  <= is_write && (cur_st == StS);
      end else begin
        bc_q    <= 1'b1;
        fetch_q <= words;
      end
    end else if (cmd_i.snoop_chk) begin
      if (!is_write && found) begin
        sup_v_q <= 1'b1;
        sup_c_q <= 2'(cnt_q);
        copy_q  <= (cur_st == StM) ? words : '0;
      end
    end else if (cmd_i.install) begin
      rep_q <= full;
      wb_q  <= vic_mod ? 19'(words) : '0;
      ns_q  <= ins_st;
    end
  end

  // Output register.
  logic        out_valid_q;
  logic        out_free;
  logic [31:0] flush_wb;

  assign out_free = !out_valid_q || out_o.ready;
  assign flush_wb = 32'(mcnt_q[CoreW'(cnt_q)]) << (blog - 4'd2);
  assign out_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.out_flush) begin
        out_o.core_id             <= 2'(cnt_q);
        out_o.hit                 <= 1'b0;
        out_o.broadcast           <= 1'b0;
        out_o.replaced            <= 1'b0;
        out_o.fetch_words         <= '0;
        out_o.writeback_words     <= 19'(flush_wb);
        out_o.supplier_valid      <= 1'b0;
        out_o.supplier_core       <= '0;
        out_o.supplier_copy_words <= '0;
        out_o.new_state           <= StI;
        out_o.last                <= sts_o.cnt_last;
      end else begin
        out_o.core_id             <= core_q;
        out_o.hit                 <= hit_q;
        out_o.broadcast           <= bc_q;
        out_o.replaced            <= rep_q;
        out_o.fetch_words         <= fetch_q;
        out_o.writeback_words     <= wb_q;
        out_o.supplier_valid      <= sup_v_q;
        out_o.supplier_core       <= sup_c_q;
        out_o.supplier_copy_words <= copy_q;
        out_o.new_state           <= ns_q;
        out_o.last                <= 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.is_flush = (kind_q == KindFlush);
    sts_o.is_write = is_write;
    sts_o.ignore   = (kind_q == KindNone) || (32'(core_q) >= 32'(ncores));
    sts_o.found    = found;
    sts_o.shared   = (cur_st == StS);
    sts_o.req_hit  = hit_q;
    sts_o.cnt_end  = (cnt_q >= ncores);
    sts_o.cnt_req  = (32'(cnt_q) == 32'(core_q));
    sts_o.cnt_last = (cnt_q == ncores - CntW'(1));
    sts_o.out_free = out_free;
  end

endmodule
`default_nettype wire

@@ rtl/mesi_snooping_lru_cache_tags_unit.sv @@
// A read hit, or a write hit to a line that is not Shared, goes from Decode through Look to Emit,
// where its result is loaded once the output is free; no new item is accepted until it is back in Idle.
// A miss or a write to a Shared line then passes over the requester's own slot, snoops each
// other active core in turn (a read miss stops at its supplier), ends a full scan and, on a
// miss, installs the line before Emit.
// A flush gives one result per active core per cycle while the output is free; reset invalidates every line at once.
`default_nettype none
module mesi_snooping_lru_cache_tags_unit
  import msct_pkg::*;
#(
  parameter int unsigned NUM_CORES = DefNumCores,
  parameter int unsigned SETS      = DefSets,
  parameter int unsigned WAYS      = DefWays
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  msct_in_if.sink    in_i,
  msct_out_if.source out_o,
  msct_cfg_if.sink   cfg_i
);

  msct_cmd_t cmd;
  msct_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  msct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  msct_dp #(
    .NUM_CORES (NUM_CORES),
    .SETS      (SETS),
    .WAYS      (WAYS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("Item accepted while the previous one is in work.");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("Result loaded over one not yet taken.");

  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cmd.rd_req || cmd.rd_snoop) && (cmd.look || cmd.snoop_chk || cmd.install)))
    else $error("Row read and row update in the same cycle.");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_clear |-> (cmd.load_out && sts.cnt_last))
    else $error("Flush cleared before its last result.");

endmodule
`default_nettype wire
